// ===== rtl/core/anh_pkg.sv =====
`default_nettype none
package anh_pkg;

    localparam int HISTORY_DEPTH = 5;
    localparam int SLOT_W        = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int CHECKED_BYTES = 3;
    localparam int BYTE_W        = (CHECKED_BYTES > 1) ? $clog2(CHECKED_BYTES) : 1;

    localparam logic [7:0] ACK_POLY         = 8'h8C;
    localparam logic [7:0] NOT_FOUND_STATUS = 8'd4;
    localparam logic [7:0] ACK_CODE_ACK     = 8'd1;
    localparam logic [7:0] ACK_CODE_NAK     = 8'd2;

    typedef enum logic [1:0] {
        OP_RECORD = 2'd0,
        OP_ACK    = 2'd1,
        OP_QUERY  = 2'd2,
        OP_UNUSED = 2'd3
    } t_opcode;

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_CRC    = 5'b00010,
        S_CHECK  = 5'b00100,
        S_SEARCH = 5'b01000,
        S_DONE   = 5'b10000
    } t_state;

    typedef struct packed {
        logic load;
        logic crc_step;
        logic check;
        logic search_step;
        logic finish;
    } t_dp_cmd;

    typedef struct packed {
        logic crc_last;
        logic check_go;
        logic search_done;
    } t_dp_sts;

    // One byte of the reflected CRC-8, least significant bit first.
    function automatic logic [7:0] crc8_byte(input logic [7:0] crc_in, input logic [7:0] data);
        logic [7:0] crc;
        logic [7:0] v;
        logic       mix;
        crc = crc_in;
        v   = data;
        for (int b = 0; b < 8; b++) begin
            mix = crc[0] ^ v[0];
            crc = crc >> 1;
            if (mix) begin
                crc = crc ^ ACK_POLY;
            end
            v = v >> 1;
        end
        return crc;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/core/anh_ctrl.sv =====
`default_nettype none
module anh_ctrl
    import anh_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       start,
    input  wire logic [1:0] i_opcode,
    input  wire t_dp_sts    i_sts,
    output t_dp_cmd         o_cmd,
    output logic            busy,
    output logic            o_done
);

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_cmd.load = 1'b1;
                    case (t_opcode'(i_opcode))
                        OP_ACK:   n_state = S_CRC;
                        OP_QUERY: n_state = S_SEARCH;
                        default:  n_state = S_DONE;
                    endcase
                end
            end
            S_CRC: begin
                o_cmd.crc_step = 1'b1;
                if (i_sts.crc_last) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                o_cmd.check = 1'b1;
                n_state     = i_sts.check_go ? S_SEARCH : S_DONE;
            end
            S_SEARCH: begin
                o_cmd.search_step = 1'b1;
                if (i_sts.search_done) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                o_cmd.finish = 1'b1;
                n_state      = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign busy   = (r_state != S_IDLE);
    assign o_done = (r_state == S_DONE);

endmodule
`default_nettype wire

// ===== rtl/core/anh_dp.sv =====
`default_nettype none
module anh_dp
    import anh_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_dp_cmd     i_cmd,
    output t_dp_sts          o_sts,
    input  wire logic        i_cfg_we,
    input  wire logic [7:0]  i_cfg_wdata,
    input  wire logic [1:0]  i_opcode,
    input  wire logic [7:0]  i_entry_address,
    input  wire logic [7:0]  i_entry_crc,
    input  wire logic [7:0]  i_entry_status,
    input  wire logic [7:0]  i_ack_lead,
    input  wire logic [7:0]  i_ack_code,
    input  wire logic [7:0]  i_ack_ref_crc,
    input  wire logic [7:0]  i_ack_check,
    output logic [7:0]       o_query_status,
    output logic             o_check_passed,
    output logic             o_ack_applied,
    output logic [15:0]      o_crc_error_total
);

    // History store.
    logic [7:0]        r_hist_addr [HISTORY_DEPTH];
    logic [7:0]        r_hist_crc  [HISTORY_DEPTH];
    logic [7:0]        r_hist_stat [HISTORY_DEPTH];
    logic [SLOT_W-1:0] r_next;

    logic [7:0]        r_reply_addr;
    logic [15:0]       r_err;

    // Latched item.
    t_opcode           r_op;
    logic [7:0]        r_addr;
    logic [7:0]        r_ecrc;
    logic [7:0]        r_estat;
    logic [7:0]        r_lead;
    logic [7:0]        r_code;
    logic [7:0]        r_ref;
    logic [7:0]        r_check;

    // Work registers.
    logic [7:0]        r_crc;
    logic [BYTE_W-1:0] r_byte;
    logic [SLOT_W-1:0] r_slot;
    logic [SLOT_W-1:0] r_age;
    logic [7:0]        r_query;
    logic              r_passed;
    logic              r_applied;

    logic [SLOT_W-1:0] newest;
    logic [7:0]        crc_byte_in;
    logic [7:0]        search_key;
    logic              hit;
    logic              age_last;
    logic              code_valid;

    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(HISTORY_DEPTH - 1);

    assign newest = (r_next == '0) ? LAST_SLOT : r_next - 1'b1;

    always_comb begin
        case (r_byte)
            BYTE_W'(0): crc_byte_in = r_lead;
            BYTE_W'(1): crc_byte_in = r_code;
            default:    crc_byte_in = r_ref;
        endcase
    end

    assign search_key = (r_op == OP_ACK) ? r_reply_addr : r_addr;
    assign hit        = (r_hist_addr[r_slot] == search_key) &&
                        ((r_op != OP_ACK) || (r_hist_crc[r_slot] == r_ref));
    assign age_last   = (r_age == LAST_SLOT);
    assign code_valid = (r_code == ACK_CODE_ACK) || (r_code == ACK_CODE_NAK);

    assign o_sts.crc_last    = (r_byte == BYTE_W'(CHECKED_BYTES - 1));
    assign o_sts.check_go    = (r_crc == r_check) && code_valid;
    assign o_sts.search_done = hit || age_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_reply_addr <= '0;
        end else if (i_cfg_we) begin
            r_reply_addr <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op    <= t_opcode'(i_opcode);
            r_addr  <= i_entry_address;
            r_ecrc  <= i_entry_crc;
            r_estat <= i_entry_status;
            r_lead  <= i_ack_lead;
            r_code  <= i_ack_code;
            r_ref   <= i_ack_ref_crc;
            r_check <= i_ack_check;
            r_crc   <= '0;
            r_byte  <= '0;
            r_slot  <= newest;
            r_age   <= '0;
        end else if (i_cmd.crc_step) begin
            r_crc  <= crc8_byte(r_crc, crc_byte_in);
            r_byte <= r_byte + 1'b1;
        end else if (i_cmd.search_step && !hit) begin
            r_slot <= (r_slot == '0) ? LAST_SLOT : r_slot - 1'b1;
            r_age  <= r_age + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < HISTORY_DEPTH; i++) begin
                r_hist_addr[i] <= '0;
                r_hist_crc[i]  <= '0;
                r_hist_stat[i] <= '0;
            end
            r_next    <= '0;
            r_err     <= '0;
            r_query   <= '0;
            r_passed  <= 1'b0;
            r_applied <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_query   <= (t_opcode'(i_opcode) == OP_QUERY) ? NOT_FOUND_STATUS : 8'd0;
                r_passed  <= 1'b0;
                r_applied <= 1'b0;
            end
            if (i_cmd.check) begin
                if (r_crc == r_check) begin
                    r_passed <= 1'b1;
                end else begin
                    r_err <= r_err + 16'd1;
                end
            end
            if (i_cmd.search_step && hit) begin
                if (r_op == OP_ACK) begin
                    r_hist_stat[r_slot] <= r_code;
                    r_applied           <= 1'b1;
                end else begin
                    r_query <= r_hist_stat[r_slot];
                end
            end
            if (i_cmd.finish && (r_op == OP_RECORD)) begin
                r_hist_addr[r_next] <= r_addr;
                r_hist_crc[r_next]  <= r_ecrc;
                r_hist_stat[r_next] <= r_estat;
                r_next              <= (r_next == LAST_SLOT) ? '0 : r_next + 1'b1;
            end
        end
    end

    assign o_query_status    = r_query;
    assign o_check_passed    = r_passed;
    assign o_ack_applied     = r_applied;
    assign o_crc_error_total = r_err;

endmodule
`default_nettype wire

// ===== rtl/core/ack_nak_history_tracker.sv =====
`default_nettype none
// Acknowledge history tracker.
// Commands enter on one input beat: the block accepts a beat at a rising edge where start
// is high and busy is low, and holds busy high until that command's result has gone out.
// Opcode 0 records a sent packet in the five-entry circular history, opcode 1 checks a
// four-byte ack frame and may update an entry's status, opcode 2 looks up the status of
// the newest entry with a given address, and opcode 3 does nothing.
// Each command yields exactly one result beat, shown for one cycle with o_done high; the
// receiver cannot stall, so it must take every result beat as it appears.
// Steps: a record or an unused opcode goes straight to its result beat; a query searches
// first, walking one history entry per cycle from newest to oldest and stopping on the
// first hit; an ack frame runs CRC-8 over its three leading bytes (one frame byte per
// cycle), then a compare, then the same entry-by-entry search when the check passes with
// a valid code.
// One command is in flight at a time; busy drops in the cycle after o_done.
// The reply address register is written through i_cfg_we and i_cfg_wdata; the user
// must change it only while no command is in flight, as the block does not enforce it.
// A synchronous reset clears the history to address 0, CRC 0, status 0, the write slot,
// the CRC error counter and the reply address; cleared entries take part in searches.
module ack_nak_history_tracker
    import anh_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic        i_cfg_we,
    input  wire logic [7:0]  i_cfg_wdata,
    input  wire logic [1:0]  i_opcode,
    input  wire logic [7:0]  i_entry_address,
    input  wire logic [7:0]  i_entry_crc,
    input  wire logic [7:0]  i_entry_status,
    input  wire logic [7:0]  i_ack_lead,
    input  wire logic [7:0]  i_ack_code,
    input  wire logic [7:0]  i_ack_ref_crc,
    input  wire logic [7:0]  i_ack_check,
    output logic             o_done,
    output logic [7:0]       o_query_status,
    output logic             o_check_passed,
    output logic             o_ack_applied,
    output logic [15:0]      o_crc_error_total
);

    t_dp_cmd cmd;
    t_dp_sts sts;

    // The controller sequences load, CRC, compare, search and finish steps.
    anh_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_opcode (i_opcode),
        .i_sts    (sts),
        .o_cmd    (cmd),
        .busy     (busy),
        .o_done   (o_done)
    );

    // The datapath holds the history, the CRC unit, the search pointer and the results.
    anh_dp u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_sts             (sts),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_wdata       (i_cfg_wdata),
        .i_opcode          (i_opcode),
        .i_entry_address   (i_entry_address),
        .i_entry_crc       (i_entry_crc),
        .i_entry_status    (i_entry_status),
        .i_ack_lead        (i_ack_lead),
        .i_ack_code        (i_ack_code),
        .i_ack_ref_crc     (i_ack_ref_crc),
        .i_ack_check       (i_ack_check),
        .o_query_status    (o_query_status),
        .o_check_passed    (o_check_passed),
        .o_ack_applied     (o_ack_applied),
        .o_crc_error_total (o_crc_error_total)
    );

`ifndef SYNTHESIS
    // A result beat only appears while a command is in flight.
    a_done_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> busy)
        else $error("result beat without a command in flight");

    // The block is free again right after its result beat.
    a_done_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !busy)
        else $error("busy did not drop after the result beat");

    // An entry can only be updated by a frame whose check passed.
    a_applied_passed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_ack_applied) |-> o_check_passed)
        else $error("ack applied without a passed check");

    // A passed check never bumps the error counter.
    a_passed_no_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_check_passed) |-> $stable(o_crc_error_total))
        else $error("error counter moved on a passed check");
`endif

endmodule
`default_nettype wire

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps

// Self-checking bench for the acknowledge history tracker.
// Every command beat that the block accepts is run through a local model of the
// five-entry history. The model predicts the one result beat that the command
// causes, and a monitor compares each o_done beat against the oldest prediction.
module tb_top
    import anh_pkg::*;
();

    localparam int RESET_CYCLES = 11;
    localparam int PHASE_BEATS  = 130;
    localparam int PHASE_COUNT  = 8;
    localparam int MAX_REPORTS  = 10;
    // The run limit lies far above what the whole run needs.
    localparam int LIMIT_CYCLES = 100_000;
    localparam int DRAIN_CYCLES = 16;

    // One command beat as it sits on the input ports.
    typedef struct packed {
        t_opcode    op;
        logic [7:0] addr;
        logic [7:0] crc;
        logic [7:0] status;
        logic [7:0] lead;
        logic [7:0] code;
        logic [7:0] ref_crc;
        logic [7:0] check;
    } t_cmd;

    localparam int CMD_W = $bits(t_cmd);

    // One result beat as it sits on the output ports.
    typedef struct packed {
        logic [7:0]  query;
        logic        passed;
        logic        applied;
        logic [15:0] err_total;
    } t_result;

    typedef enum bit {
        ROW_BEAT,
        ROW_REG
    } t_row_kind;

    // A row of the directed table. For an ack row the check field is an xor mask
    // over the correct check byte, so zero means a good frame. A ROW_REG row
    // writes the reply address held in the addr field.
    typedef struct packed {
        t_row_kind kind;
        t_cmd      cmd;
        bit        typed;
        t_result   want;
    } t_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic        i_cfg_we;
    logic [7:0]  i_cfg_wdata;
    logic [1:0]  i_opcode;
    logic [7:0]  i_entry_address;
    logic [7:0]  i_entry_crc;
    logic [7:0]  i_entry_status;
    logic [7:0]  i_ack_lead;
    logic [7:0]  i_ack_code;
    logic [7:0]  i_ack_ref_crc;
    logic [7:0]  i_ack_check;
    logic        o_done;
    logic [7:0]  o_query_status;
    logic        o_check_passed;
    logic        o_ack_applied;
    logic [15:0] o_crc_error_total;

    // Model of the history: one entry per slot, the slot to write next, the
    // count of failed frames and the reply address register.
    logic [7:0]  hist_addr   [HISTORY_DEPTH];
    logic [7:0]  hist_crc    [HISTORY_DEPTH];
    logic [7:0]  hist_status [HISTORY_DEPTH];
    int          wr_slot;
    logic [15:0] failed_frames;
    logic [7:0]  reply_addr_model;

    // Addresses and CRCs that the random records and queries mostly draw from,
    // so that entries repeat and searches hit.
    logic [7:0]  addr_pool [4];
    logic [7:0]  crc_pool  [4];

    t_result     replies_due [$];
    t_row        directed_rows [$];
    bit          gaps_on;
    int          mismatches;
    int          cycle_count;

    ack_nak_history_tracker u_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .start             (start),
        .busy              (busy),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_wdata       (i_cfg_wdata),
        .i_opcode          (i_opcode),
        .i_entry_address   (i_entry_address),
        .i_entry_crc       (i_entry_crc),
        .i_entry_status    (i_entry_status),
        .i_ack_lead        (i_ack_lead),
        .i_ack_code        (i_ack_code),
        .i_ack_ref_crc     (i_ack_ref_crc),
        .i_ack_check       (i_ack_check),
        .o_done            (o_done),
        .o_query_status    (o_query_status),
        .o_check_passed    (o_check_passed),
        .o_ack_applied     (o_ack_applied),
        .o_crc_error_total (o_crc_error_total)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Reflected CRC-8 over the three leading frame bytes, taken as one 24-bit
    // stream that starts at the least significant bit of the lead byte.
    function automatic logic [7:0] frame_crc8(input logic [7:0] b0, input logic [7:0] b1,
                                              input logic [7:0] b2);
        logic [23:0] stream;
        logic [7:0]  rem;
        stream = {b2, b1, b0};
        rem    = 8'h00;
        for (int i = 0; i < 24; i++) begin
            rem = (rem[0] ^ stream[i]) ? ((rem >> 1) ^ ACK_POLY) : (rem >> 1);
        end
        return rem;
    endfunction

    // Applies one accepted command to the model and returns the result beat
    // that the block must produce for it.
    function automatic t_result history_step(input t_cmd c);
        t_result res;
        int      slot;
        bit      found;
        res       = '0;
        found     = 1'b0;
        case (c.op)
            OP_RECORD: begin
                hist_addr[wr_slot]   = c.addr;
                hist_crc[wr_slot]    = c.crc;
                hist_status[wr_slot] = c.status;
                wr_slot              = (wr_slot + 1) % HISTORY_DEPTH;
            end
            OP_ACK: begin
                if (frame_crc8(c.lead, c.code, c.ref_crc) == c.check) begin
                    res.passed = 1'b1;
                    // Only an ack or a nak code touches the history, and then
                    // only the newest entry that matches both address and CRC.
                    if (c.code == ACK_CODE_ACK || c.code == ACK_CODE_NAK) begin
                        for (int age = 0; age < HISTORY_DEPTH; age++) begin
                            slot = (wr_slot + HISTORY_DEPTH - 1 - age) % HISTORY_DEPTH;
                            if (!found && hist_addr[slot] == reply_addr_model
                                    && hist_crc[slot] == c.ref_crc) begin
                                hist_status[slot] = c.code;
                                res.applied       = 1'b1;
                                found             = 1'b1;
                            end
                        end
                    end
                end else begin
                    failed_frames = failed_frames + 16'd1;
                end
            end
            OP_QUERY: begin
                res.query = NOT_FOUND_STATUS;
                for (int age = 0; age < HISTORY_DEPTH; age++) begin
                    slot = (wr_slot + HISTORY_DEPTH - 1 - age) % HISTORY_DEPTH;
                    if (!found && hist_addr[slot] == c.addr) begin
                        res.query = hist_status[slot];
                        found     = 1'b1;
                    end
                end
            end
            default: begin
            end
        endcase
        res.err_total = failed_frames;
        return res;
    endfunction

    // Random command beat. Most beats are records, acks and queries built from
    // the pools and the current history, so that acks pass their check and find
    // entries; the rest are fully random fields and unused opcodes.
    function automatic t_cmd random_beat();
        t_cmd       c;
        int         pick;
        logic [7:0] good;
        c    = CMD_W'({$urandom, $urandom});
        pick = $urandom_range(0, 99);
        if (pick < 30) begin
            c.op = OP_RECORD;
            if ($urandom_range(0, 3) != 0) c.addr = addr_pool[$urandom_range(0, 3)];
            if ($urandom_range(0, 3) != 0) c.crc  = crc_pool[$urandom_range(0, 3)];
        end else if (pick < 65) begin
            c.op = OP_ACK;
            if ($urandom_range(0, 9) < 7) c.code = 8'($urandom_range(1, 2));
            if ($urandom_range(0, 9) < 7) begin
                c.ref_crc = hist_crc[$urandom_range(0, HISTORY_DEPTH - 1)];
            end else if ($urandom_range(0, 1) == 0) begin
                c.ref_crc = crc_pool[$urandom_range(0, 3)];
            end
            good    = frame_crc8(c.lead, c.code, c.ref_crc);
            c.check = ($urandom_range(0, 4) != 0) ? good : good ^ 8'($urandom_range(1, 255));
        end else if (pick < 95) begin
            c.op = OP_QUERY;
            if ($urandom_range(0, 4) != 0) c.addr = addr_pool[$urandom_range(0, 3)];
        end else begin
            c.op = OP_UNUSED;
        end
        return c;
    endfunction

    task automatic plan_row(input t_row_kind kind, input t_opcode op,
                            input logic [7:0] addr, input logic [7:0] crc,
                            input logic [7:0] status, input logic [7:0] lead,
                            input logic [7:0] code, input logic [7:0] ref_crc,
                            input logic [7:0] check, input bit typed,
                            input logic [7:0] query, input logic passed,
                            input logic applied, input logic [15:0] err_total);
        t_row r;
        r.kind  = kind;
        r.cmd   = {op, addr, crc, status, lead, code, ref_crc, check};
        r.typed = typed;
        r.want  = {query, passed, applied, err_total};
        directed_rows.push_back(r);
    endtask

    // Presents one command beat and holds it until the block takes it. The
    // expectation is queued at the accepting edge; an earliest result comes in the
    // cycle after it, so the monitor never races this push.
    task automatic issue_beat(input t_cmd c, input bit typed, input t_result want);
        t_result predicted;
        start           <= 1'b1;
        i_opcode        <= c.op;
        i_entry_address <= c.addr;
        i_entry_crc     <= c.crc;
        i_entry_status  <= c.status;
        i_ack_lead      <= c.lead;
        i_ack_code      <= c.code;
        i_ack_ref_crc   <= c.ref_crc;
        i_ack_check     <= c.check;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        predicted = history_step(c);
        replies_due.push_back(typed ? want : predicted);
        // Sender idles in short bursts; otherwise start stays high and the next
        // beat waits on busy.
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
    endtask

    // The reply address is only changed with no command in flight, so that
    // the model and the block agree on which beats saw which value.
    task automatic set_reply_address(input logic [7:0] value);
        start <= 1'b0;
        while (replies_due.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we         <= 1'b0;
        reply_addr_model  = value;
    endtask

    // Result monitor: the receiver cannot stall, so every o_done beat is taken.
    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (i_rst_n && o_done) begin
            got = {o_query_status, o_check_passed, o_ack_applied, o_crc_error_total};
            if (replies_due.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS) begin
                    $display("result beat with nothing pending: query %0h passed %0b",
                             got.query, got.passed);
                end
            end else begin
                want = replies_due.pop_front();
                if (got.query !== want.query || got.passed !== want.passed
                        || got.applied !== want.applied
                        || got.err_total !== want.err_total) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS) begin
                        $display("mismatch: query exp %0h got %0h, passed exp %0b got %0b",
                                 want.query, got.query, want.passed, got.passed);
                        $display("          applied exp %0b got %0b, errors exp %0d got %0d",
                                 want.applied, got.applied, want.err_total, got.err_total);
                    end
                end
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES) begin
            $display("FAIL ack_nak_history_tracker");
            $finish;
        end
    end

    initial begin
        logic [7:0] reply_plan [PHASE_COUNT];
        t_cmd       c;
        t_row       r;

        cycle_count      = 0;
        mismatches       = 0;
        gaps_on          = 1'b1;
        wr_slot          = 0;
        failed_frames    = 16'd0;
        reply_addr_model = 8'h00;
        for (int i = 0; i < HISTORY_DEPTH; i++) begin
            hist_addr[i]   = 8'h00;
            hist_crc[i]    = 8'h00;
            hist_status[i] = 8'h00;
        end

        i_rst_n         <= 1'b0;
        start           <= 1'b0;
        i_cfg_we        <= 1'b0;
        i_cfg_wdata     <= 8'h00;
        i_opcode        <= OP_UNUSED;
        i_entry_address <= 8'h00;
        i_entry_crc     <= 8'h00;
        i_entry_status  <= 8'h00;
        i_ack_lead      <= 8'h00;
        i_ack_code      <= 8'h00;
        i_ack_ref_crc   <= 8'h00;
        i_ack_check     <= 8'h00;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed table. Typed expectations appear only where they are plain:
        // cleared history, a miss, failed frames and the unused opcode. The
        // reply address starts at its reset value of zero.
        // Cleared entries are real entries with address 0 and status 0.
        plan_row(ROW_BEAT, OP_QUERY,  'h00, 'h00, 'h00, 'h00, 'h00, 'h00, 'h00, 1, 'h00, 0, 0, 0);
        plan_row(ROW_BEAT, OP_QUERY,  'hFF, 'h00, 'h00, 'h00, 'h00, 'h00, 'h00, 1, 'h04, 0, 0, 0);
        plan_row(ROW_BEAT, OP_ACK,    'h00, 'h00, 'h00, 'h00, 'h01, 'h00, 'h01, 1, 'h00, 0, 0, 1);
        // A good ack for CRC 0 lands on a cleared entry.
        plan_row(ROW_BEAT, OP_ACK,    'h00, 'h00, 'h00, 'hA5, 'h01, 'h00, 'h00, 0, 0, 0, 0, 0);
        plan_row(ROW_BEAT, OP_QUERY,  'h00, 'h00, 'h00, 'h00, 'h00, 'h00, 'h00, 0, 0, 0, 0, 0);
        plan_row(ROW_BEAT, OP_RECORD, 'hFF, 'hFF, 'hFF, 'h00, 'h00, 'h00, 'h00, 0, 0, 0, 0, 0);
        plan_row(ROW_BEAT, OP_RECORD, 'h00, 'h00, 'h00, 'h00, 'h00, 'h00, 'h00, 0, 0, 0, 0, 0);
        plan_row(ROW_BEAT, OP_RECORD, 'h00, 'h33, 'h80, 'h00, 'h00, 'h00, 'h00, 0, 0, 0, 0, 0);
        // Several entries match address 0 and CRC 0; only the newest changes.
        plan_row(ROW_BEAT, OP_ACK,    'h00, 'h00, 'h00, 'hFF, 'h02, 'h00, 'h00, 0, 0, 0, 0, 0);
        plan_row(ROW_BEAT, OP_QUERY,  'h00, 'h00, 'h00, 'h00, 'h00, 'h00, 'h00, 0, 0, 0, 0, 0);
        // Good frames whose code is neither ack nor nak change nothing.
        plan_row(ROW_BEAT, OP_ACK,    'h00, 'h00, 'h00, 'h11, 'h00, 'h33, 'h00, 0, 0, 0, 0, 0);
        plan_row(ROW_BEAT, OP_ACK,    'h00, 'h00, 'h00, 'h22, 'h03, 'h33, 'h00, 0, 0, 0, 0, 0);
        plan_row(ROW_BEAT, OP_ACK,    'h00, 'h00, 'h00, 'h33, 'hFF, 'h33, 'h00, 0, 0, 0, 0, 0);
        plan_row(ROW_BEAT, OP_UNUSED, 'hFF, 'hFF, 'hFF, 'hFF, 'hFF, 'hFF, 'hFF, 1, 'h00, 0, 0, 1);
        plan_row(ROW_REG,  OP_UNUSED, 'hFF, 'h00, 'h00, 'h00, 'h00, 'h00, 'h00, 0, 0, 0, 0, 0);
        plan_row(ROW_BEAT, OP_ACK,    'h00, 'h00, 'h00, 'h5A, 'h01, 'hFF, 'h00, 0, 0, 0, 0, 0);
        plan_row(ROW_BEAT, OP_QUERY,  'hFF, 'h00, 'h00, 'h00, 'h00, 'h00, 'h00, 0, 0, 0, 0, 0);
        // Good frame that names a CRC nobody holds.
        plan_row(ROW_BEAT, OP_ACK,    'h00, 'h00, 'h00, 'h00, 'h02, 'h12, 'h00, 0, 0, 0, 0, 0);
        plan_row(ROW_BEAT, OP_ACK,    'h00, 'h00, 'h00, 'hFF, 'hFF, 'hFF, 'hFF, 1, 'h00, 0, 0, 2);
        plan_row(ROW_BEAT, OP_RECORD, 'hFF, 'h10, 'h07, 'h00, 'h00, 'h00, 'h00, 0, 0, 0, 0, 0);
        plan_row(ROW_BEAT, OP_RECORD, 'hFF, 'h10, 'h08, 'h00, 'h00, 'h00, 'h00, 0, 0, 0, 0, 0);
        plan_row(ROW_BEAT, OP_ACK,    'h00, 'h00, 'h00, 'h01, 'h02, 'h10, 'h00, 0, 0, 0, 0, 0);
        plan_row(ROW_BEAT, OP_QUERY,  'hFF, 'h00, 'h00, 'h00, 'h00, 'h00, 'h00, 0, 0, 0, 0, 0);
        plan_row(ROW_REG,  OP_UNUSED, 'h00, 'h00, 'h00, 'h00, 'h00, 'h00, 'h00, 0, 0, 0, 0, 0);
        plan_row(ROW_BEAT, OP_QUERY,  'h00, 'h00, 'h00, 'h00, 'h00, 'h00, 'h00, 0, 0, 0, 0, 0);

        foreach (directed_rows[i]) begin
            r = directed_rows[i];
            if (r.kind == ROW_REG) begin
                set_reply_address(r.cmd.addr);
            end else begin
                c = r.cmd;
                if (c.op == OP_ACK) begin
                    c.check = frame_crc8(c.lead, c.code, c.ref_crc) ^ c.check;
                end
                issue_beat(c, r.typed, r.want);
            end
        end

        // Random phases, each under its own reply address, the extremes among them.
        reply_plan[0] = 8'h00;
        reply_plan[1] = 8'hFF;
        reply_plan[2] = 8'($urandom);
        reply_plan[3] = 8'h80;
        reply_plan[4] = 8'($urandom);
        reply_plan[5] = 8'h01;
        reply_plan[6] = 8'($urandom);
        reply_plan[7] = 8'h7F;
        for (int p = 0; p < PHASE_COUNT; p++) begin
            set_reply_address(reply_plan[p]);
            addr_pool[0] = reply_plan[p];
            addr_pool[1] = reply_plan[p] ^ 8'h01;
            addr_pool[2] = 8'($urandom);
            addr_pool[3] = 8'h00;
            for (int i = 0; i < 4; i++) crc_pool[i] = 8'($urandom);
            // The closing phase runs with start held high throughout.
            gaps_on = (p != PHASE_COUNT - 1);
            for (int n = 0; n < PHASE_BEATS; n++) begin
                issue_beat(random_beat(), 1'b0, '0);
            end
        end

        start <= 1'b0;
        while (replies_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("PASS ack_nak_history_tracker");
        end else begin
            $display("FAIL ack_nak_history_tracker");
        end
        $finish;
    end

endmodule

// ===== ack_nak_history_tracker.f =====
rtl/core/anh_pkg.sv
rtl/core/anh_ctrl.sv
rtl/core/anh_dp.sv
rtl/core/ack_nak_history_tracker.sv
bench/tb_top.sv
